// ----- rtl/dst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants for the detection spot table
// Sequencer states, update actions and the control word of the distance unit.
// ----------------------------------------------------------------------------
package dst_pkg;

	localparam int DST_SPOTS = 4;
	localparam logic [31:0] DST_PROX_RESET = 32'd196608;
	localparam logic [15:0] DST_COUNT_MAX = 16'hFFFF;

	// width of one axis operand after abs(): covers |-2^24|
	localparam int DST_OPW = 25;
	localparam int DST_SQW = 2 * DST_OPW;

	typedef enum logic [1:0] {
		ACT_MERGE   = 2'd0,
		ACT_FILL    = 2'd1,
		ACT_REPLACE = 2'd2
	} dst_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_CMP,
		ST_WRITE,
		ST_BEST,
		ST_DONE
	} dst_state_t;

	typedef struct packed {
		logic mul_en;  // register a new square
		logic load;    // move the held square into the accumulator
	} dst_sq_ctl_t;

endpackage

// ----- rtl/dst_sqacc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_sqacc: shared squaring unit for the proximity test
// Squares one axis difference per cycle while mul_en is set, holds the first
// square, and compares the sum of both squares against the merge threshold.
// ----------------------------------------------------------------------------
module dst_sqacc (
	input  logic                     clk,
	input  dst_pkg::dst_sq_ctl_t     ctl,
	input  logic [dst_pkg::DST_OPW-1:0] operand,
	input  logic [31:0]              prox,
	output logic                     near
);
	import dst_pkg::*;

	logic [DST_SQW-1:0] prod_c;
	logic [DST_SQW-1:0] prod_s1;
	logic [DST_SQW-1:0] acc_q;
	logic [DST_SQW-1:0] sum_c;

	assign prod_c = operand * operand;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= prod_c;
		end
		if (ctl.load) begin
			acc_q <= prod_s1;
		end
	end

	// squares are at most 2^48 each, so the sum never wraps
	assign sum_c = acc_q + prod_s1;
	assign near  = (sum_c[DST_SQW-1:32] == '0) && (sum_c[31:0] < prox);

endmodule

// ----- rtl/detection_spot_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_spot_table: merge ground detections into a small spot table
// Proximity merge, empty fill or lowest-score replace, then best-spot report.
// ----------------------------------------------------------------------------
// Sequence: each slot tested for proximity passes through MUL_X, MUL_Y and CMP
// (one shared squarer); if nothing merges, a WRITE state follows; then a BEST
// scan over all SPOTS slots and the DONE output state.
// Throughput: one word at a time; a new word is accepted only in IDLE, and the
// previous result may still wait at the output.
// Reset clears every spot to zero (empty) and sets the threshold to 3.0 m^2.
module detection_spot_table #(
	parameter int SPOTS = dst_pkg::DST_SPOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// det_x[23:0], det_y[47:24], det_score[63:48]
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// action[1:0], slot[3:2], slot_x[27:4], slot_y[51:28], slot_score[67:52],
	// slot_count[83:68], best_valid[84], best_slot[86:85], best_x[110:87],
	// best_y[134:111], zero[135]
	output logic [135:0] m_axis_tdata
);
	import dst_pkg::*;

	localparam int IW = (SPOTS > 1) ? $clog2(SPOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SPOTS - 1);

	dst_state_t state_q, state_d;
	logic [IW-1:0] idx_q;
	logic [31:0] prox_q;

	logic [23:0] det_x_q, det_y_q;
	logic [15:0] det_score_q;

	logic [23:0] spot_x_q     [SPOTS];
	logic [23:0] spot_y_q     [SPOTS];
	logic [15:0] spot_score_q [SPOTS];
	logic [15:0] spot_count_q [SPOTS];

	logic          empty_found_q;
	logic [IW-1:0] empty_idx_q;
	logic [16:0]   min_score_q;
	logic [IW-1:0] min_idx_q;

	dst_action_t   action_q;
	logic [IW-1:0] upd_idx_q;
	logic [23:0]   upd_x_q, upd_y_q;
	logic [15:0]   upd_score_q, upd_count_q;

	logic          best_found_q;
	logic [15:0]   best_score_q;
	logic [IW-1:0] best_idx_q;
	logic [23:0]   best_x_q, best_y_q;

	logic [135:0] m_tdata_q;
	logic         m_tvalid_q;

	logic [23:0] rd_x, rd_y;
	logic [15:0] rd_score, rd_count;
	logic [23:0] op_a, op_b;
	logic [24:0] diff, mag;
	logic [24:0] sum_x, sum_y;
	logic [16:0] sum_s;
	logic [15:0] cnt_inc;
	logic [IW-1:0] wr_idx;
	logic        near;
	logic        s_accept;
	logic        out_free;
	dst_sq_ctl_t sq_ctl;

	assign rd_x     = spot_x_q[idx_q];
	assign rd_y     = spot_y_q[idx_q];
	assign rd_score = spot_score_q[idx_q];
	assign rd_count = spot_count_q[idx_q];

	// axis difference for the squarer: y on the second pass
	assign op_a = (state_q == ST_MUL_Y) ? det_y_q : det_x_q;
	assign op_b = (state_q == ST_MUL_Y) ? rd_y : rd_x;
	assign diff = {op_a[23], op_a} - {op_b[23], op_b};
	assign mag  = diff[24] ? (~diff + 25'd1) : diff;

	assign sq_ctl.mul_en = (state_q == ST_MUL_X) || (state_q == ST_MUL_Y);
	assign sq_ctl.load   = (state_q == ST_MUL_Y);

	dst_sqacc u_sqacc (
		.clk     (clk),
		.ctl     (sq_ctl),
		.operand (mag),
		.prox    (prox_q),
		.near    (near)
	);

	// floor averages: signed sum for positions, unsigned for the score, drop the low bit
	assign sum_x   = {rd_x[23], rd_x} + {det_x_q[23], det_x_q};
	assign sum_y   = {rd_y[23], rd_y} + {det_y_q[23], det_y_q};
	assign sum_s   = {1'b0, rd_score} + {1'b0, det_score_q};
	assign cnt_inc = (rd_count == DST_COUNT_MAX) ? rd_count : rd_count + 16'd1;
	assign wr_idx  = empty_found_q ? empty_idx_q : min_idx_q;

	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) state_d = ST_MUL_X;
			end
			ST_MUL_X: state_d = ST_MUL_Y;
			ST_MUL_Y: state_d = ST_CMP;
			ST_CMP: begin
				if (near) state_d = ST_BEST;
				else if (idx_q == LAST) state_d = ST_WRITE;
				else state_d = ST_MUL_X;
			end
			ST_WRITE: state_d = ST_BEST;
			ST_BEST: begin
				if (idx_q == LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prox_q        <= DST_PROX_RESET;
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			min_score_q   <= 17'h10000;
			min_idx_q     <= '0;
			action_q      <= ACT_MERGE;
			upd_idx_q     <= '0;
			best_found_q  <= 1'b0;
			best_score_q  <= '0;
			best_idx_q    <= '0;
			best_x_q      <= '0;
			best_y_q      <= '0;
			m_tvalid_q    <= 1'b0;
			for (int i = 0; i < SPOTS; i++) begin
				spot_x_q[i]     <= '0;
				spot_y_q[i]     <= '0;
				spot_score_q[i] <= '0;
				spot_count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) prox_q <= cfg_wdata;

			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						idx_q         <= '0;
						empty_found_q <= 1'b0;
						min_score_q   <= 17'h10000;
						min_idx_q     <= '0;
						best_found_q  <= 1'b0;
						best_score_q  <= '0;
						best_idx_q    <= '0;
						best_x_q      <= '0;
						best_y_q      <= '0;
					end
				end
				ST_MUL_X: begin
					// fallback candidates ride along with the proximity pass
					if (!empty_found_q && rd_count == '0) begin
						empty_found_q <= 1'b1;
						empty_idx_q   <= idx_q;
					end
					if ({1'b0, rd_score} < min_score_q) begin
						min_score_q <= {1'b0, rd_score};
						min_idx_q   <= idx_q;
					end
				end
				ST_CMP: begin
					if (near) begin
						spot_x_q[idx_q]     <= sum_x[24:1];
						spot_y_q[idx_q]     <= sum_y[24:1];
						spot_score_q[idx_q] <= sum_s[16:1];
						spot_count_q[idx_q] <= cnt_inc;
						action_q    <= ACT_MERGE;
						upd_idx_q   <= idx_q;
						upd_x_q     <= sum_x[24:1];
						upd_y_q     <= sum_y[24:1];
						upd_score_q <= sum_s[16:1];
						upd_count_q <= cnt_inc;
						idx_q       <= '0;
					end else if (idx_q != LAST) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WRITE: begin
					spot_x_q[wr_idx]     <= det_x_q;
					spot_y_q[wr_idx]     <= det_y_q;
					spot_score_q[wr_idx] <= det_score_q;
					spot_count_q[wr_idx] <= 16'd1;
					action_q    <= empty_found_q ? ACT_FILL : ACT_REPLACE;
					upd_idx_q   <= wr_idx;
					upd_x_q     <= det_x_q;
					upd_y_q     <= det_y_q;
					upd_score_q <= det_score_q;
					upd_count_q <= 16'd1;
					idx_q       <= '0;
				end
				ST_BEST: begin
					if (rd_count != '0 && rd_score > best_score_q) begin
						best_found_q <= 1'b1;
						best_score_q <= rd_score;
						best_idx_q   <= idx_q;
						best_x_q     <= rd_x;
						best_y_q     <= rd_y;
					end
					if (idx_q != LAST) idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			det_x_q     <= s_axis_tdata[23:0];
			det_y_q     <= s_axis_tdata[47:24];
			det_score_q <= s_axis_tdata[63:48];
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {1'b0, best_y_q, best_x_q, 2'(best_idx_q), best_found_q,
				upd_count_q, upd_score_q, upd_y_q, upd_x_q, 2'(upd_idx_q), action_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q == ST_MUL_X)
		else $error("accepted word did not start the proximity pass");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("undefined action code on output");

	a_no_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[84]) |-> m_axis_tdata[134:85] == '0)
		else $error("best fields not zero without a best spot");

	a_fill_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> m_axis_tdata[83:68] == 16'd1)
		else $error("filled or replaced spot with count other than one");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for detection_spot_table
// Drives ground detections over the input stream and checks every report word
// against a spot-table predictor, or a typed row's fixed values. Directed rows
// lead; random phases under several merge thresholds and back-pressure follow.
// ----------------------------------------------------------------------------
module testbench;
	import dst_pkg::*;

	localparam int SPOT_N = DST_SPOTS;
	localparam int SETTLE = 4 * SPOT_N + 6;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 215;
	localparam int HUBS = 6;
	localparam int MAX_REPORTS = 60;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	typedef struct packed {
		logic [15:0] score;
		logic [23:0] y;
		logic [23:0] x;
	} det_t;

	typedef struct packed {
		dst_action_t action;
		logic [1:0]  slot;
		logic [23:0] slot_x;
		logic [23:0] slot_y;
		logic [15:0] slot_score;
		logic [15:0] slot_count;
		logic        best_valid;
		logic [1:0]  best_slot;
		logic [23:0] best_x;
		logic [23:0] best_y;
	} spot_result_t;

	typedef enum logic {
		ROW_DET,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		det_t         det;
		logic [31:0]  radius;
		logic         fixed;
		spot_result_t want;
	} plan_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// det_x[23:0], det_y[47:24], det_score[63:48]
	logic [63:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// action[1:0], slot[3:2], slot_x[27:4], slot_y[51:28], slot_score[67:52],
	// slot_count[83:68], best_valid[84], best_slot[86:85], best_x[110:87],
	// best_y[134:111], zero[135]
	logic [135:0] m_axis_tdata;

	// predictor state
	logic [31:0] merge_radius_sq;
	logic [23:0] tbl_north [SPOT_N];
	logic [23:0] tbl_east [SPOT_N];
	logic [15:0] tbl_conf [SPOT_N];
	logic [15:0] tbl_hits [SPOT_N];

	spot_result_t pending_reports [$];
	plan_row_t    plan [$];
	logic [23:0]  hub_x [HUBS];
	logic [23:0]  hub_y [HUBS];

	int unsigned cycle_count;
	int          fail_count;
	int          words_out;
	int          dets_in;
	int          cfg_writes;
	int          act_seen [4];
	logic        idle_en;
	logic        hold_req;

	detection_spot_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d words still expected",
			cycle_count, pending_reports.size());
		$display("Test completed with failures");
		$finish;
	end

	// floor((a + b) / 2) of two signed 24-bit positions
	function automatic logic [23:0] midpoint24(logic [23:0] a, logic [23:0] b);
		logic signed [24:0] s;
		s = $signed({a[23], a}) + $signed({b[23], b});
		return s[24:1];
	endfunction

	function automatic spot_result_t apply_detection(det_t d);
		spot_result_t r;
		longint       ex;
		longint       ey;
		logic [63:0]  gap_sq;
		logic [16:0]  sum;
		logic [16:0]  low;
		logic [15:0]  top;
		int           hit;
		int           best;
		int           i;
		r = '0;
		hit = -1;
		// empty slots take part too, against their stored position
		for (i = 0; i < SPOT_N && hit < 0; i++) begin
			ex = longint'($signed(d.x)) - longint'($signed(tbl_north[i]));
			ey = longint'($signed(d.y)) - longint'($signed(tbl_east[i]));
			gap_sq = ex * ex + ey * ey;
			if (gap_sq < {32'd0, merge_radius_sq}) begin
				hit = i;
				r.action = ACT_MERGE;
				tbl_north[i] = midpoint24(tbl_north[i], d.x);
				tbl_east[i] = midpoint24(tbl_east[i], d.y);
				sum = {1'b0, tbl_conf[i]} + {1'b0, d.score};
				tbl_conf[i] = sum[16:1];
				if (tbl_hits[i] != DST_COUNT_MAX)
					tbl_hits[i] = tbl_hits[i] + 16'd1;
			end
		end
		if (hit < 0) begin
			for (i = 0; i < SPOT_N; i++) begin
				if (hit < 0 && tbl_hits[i] == 16'd0) begin
					hit = i;
					r.action = ACT_FILL;
				end
			end
			if (hit < 0) begin
				r.action = ACT_REPLACE;
				low = 17'h10000;
				for (i = 0; i < SPOT_N; i++) begin
					if ({1'b0, tbl_conf[i]} < low) begin
						low = {1'b0, tbl_conf[i]};
						hit = i;
					end
				end
			end
			tbl_north[hit] = d.x;
			tbl_east[hit] = d.y;
			tbl_conf[hit] = d.score;
			tbl_hits[hit] = 16'd1;
		end
		top = 16'd0;
		best = -1;
		for (i = 0; i < SPOT_N; i++) begin
			if (tbl_hits[i] != 16'd0 && tbl_conf[i] > top) begin
				top = tbl_conf[i];
				best = i;
			end
		end
		r.slot = 2'(hit);
		r.slot_x = tbl_north[hit];
		r.slot_y = tbl_east[hit];
		r.slot_score = tbl_conf[hit];
		r.slot_count = tbl_hits[hit];
		if (best >= 0) begin
			r.best_valid = 1'b1;
			r.best_slot = 2'(best);
			r.best_x = tbl_north[best];
			r.best_y = tbl_east[best];
		end
		return r;
	endfunction

	function automatic det_t draw_detection();
		det_t d;
		int   pick;
		int   h;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			h = $urandom_range(0, HUBS - 1);
			d.x = hub_x[h] + 24'($urandom_range(0, 1023)) - 24'd512;
			d.y = hub_y[h] + 24'($urandom_range(0, 1023)) - 24'd512;
		end else if (pick < 75) begin
			d.x = 24'($urandom_range(0, 1023)) - 24'd512;
			d.y = 24'($urandom_range(0, 1023)) - 24'd512;
		end else if (pick < 92) begin
			d.x = 24'($urandom);
			d.y = 24'($urandom);
		end else begin
			d.x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			d.y = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h800000;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55)
			d.score = 16'($urandom);
		else if (pick < 70)
			d.score = 16'h0000;
		else if (pick < 82)
			d.score = 16'hFFFF;
		else
			d.score = $urandom_range(0, 1) ? 16'h0001 : 16'h8000;
		return d;
	endfunction

	function automatic plan_row_t det_row(logic [23:0] x, logic [23:0] y, logic [15:0] s);
		plan_row_t row;
		row = '0;
		row.kind = ROW_DET;
		row.det.x = x;
		row.det.y = y;
		row.det.score = s;
		return row;
	endfunction

	function automatic plan_row_t det_typed(logic [23:0] x, logic [23:0] y, logic [15:0] s,
			dst_action_t a, logic [1:0] sl, logic [23:0] sx, logic [23:0] sy,
			logic [15:0] ss, logic [15:0] sc, logic bv, logic [1:0] bs,
			logic [23:0] bx, logic [23:0] by);
		plan_row_t row;
		row = det_row(x, y, s);
		row.fixed = 1'b1;
		row.want.action = a;
		row.want.slot = sl;
		row.want.slot_x = sx;
		row.want.slot_y = sy;
		row.want.slot_score = ss;
		row.want.slot_count = sc;
		row.want.best_valid = bv;
		row.want.best_slot = bs;
		row.want.best_x = bx;
		row.want.best_y = by;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic [31:0] v);
		plan_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.radius = v;
		return row;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH t=%0t word %0d %s: got %h want %h",
				$time, words_out, what, got, want);
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// called just after a falling edge, returns just after one
	task automatic push_detection(det_t d, logic fixed, spot_result_t want);
		int           gap;
		spot_result_t model;
		gap = 0;
		if (idle_en && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		model = apply_detection(d);
		act_seen[model.action]++;
		pending_reports.push_back(fixed ? want : model);
		dets_in++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_proximity(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		merge_radius_sq = v;
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : sink
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4);
			end
			m_axis_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin : check_reports
		spot_result_t got;
		spot_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.action = dst_action_t'(m_axis_tdata[1:0]);
			got.slot = m_axis_tdata[3:2];
			got.slot_x = m_axis_tdata[27:4];
			got.slot_y = m_axis_tdata[51:28];
			got.slot_score = m_axis_tdata[67:52];
			got.slot_count = m_axis_tdata[83:68];
			got.best_valid = m_axis_tdata[84];
			got.best_slot = m_axis_tdata[86:85];
			got.best_x = m_axis_tdata[110:87];
			got.best_y = m_axis_tdata[134:111];
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected word", 32'(m_axis_tdata[31:0]), 32'd0);
			end else begin
				want = pending_reports.pop_front();
				check_field("action", 32'(got.action), 32'(want.action));
				check_field("slot", 32'(got.slot), 32'(want.slot));
				check_field("slot_x", 32'(got.slot_x), 32'(want.slot_x));
				check_field("slot_y", 32'(got.slot_y), 32'(want.slot_y));
				check_field("slot_score", 32'(got.slot_score), 32'(want.slot_score));
				check_field("slot_count", 32'(got.slot_count), 32'(want.slot_count));
				check_field("best_valid", 32'(got.best_valid), 32'(want.best_valid));
				check_field("best_slot", 32'(got.best_slot), 32'(want.best_slot));
				check_field("best_x", 32'(got.best_x), 32'(want.best_x));
				check_field("best_y", 32'(got.best_y), 32'(want.best_y));
				check_field("pad", 32'(m_axis_tdata[135]), 32'd0);
			end
			words_out++;
		end
	end

	initial begin : stimulus
		logic [31:0] radius;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 32'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 64'd0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		fail_count = 0;
		words_out = 0;
		dets_in = 0;
		cfg_writes = 0;
		foreach (act_seen[h])
			act_seen[h] = 0;
		merge_radius_sq = DST_PROX_RESET;
		foreach (tbl_north[h]) begin
			tbl_north[h] = '0;
			tbl_east[h] = '0;
			tbl_conf[h] = '0;
			tbl_hits[h] = '0;
		end

		// first word merges into the empty slot at the origin; score zero -> no best
		plan.push_back(det_typed(24'h000000, 24'h000000, 16'h0000, ACT_MERGE, 2'd0,
			24'h000000, 24'h000000, 16'h0000, 16'd1, 1'b0, 2'd0, 24'h000000, 24'h000000));
		plan.push_back(det_typed(24'h000000, 24'h000000, 16'h8000, ACT_MERGE, 2'd0,
			24'h000000, 24'h000000, 16'h4000, 16'd2, 1'b1, 2'd0, 24'h000000, 24'h000000));
		plan.push_back(det_typed(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, ACT_FILL, 2'd1,
			24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'd1, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		plan.push_back(det_typed(24'h800000, 24'h800000, 16'h0000, ACT_FILL, 2'd2,
			24'h800000, 24'h800000, 16'h0000, 16'd1, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		plan.push_back(det_typed(24'h7FFFFF, 24'h800000, 16'h0001, ACT_FILL, 2'd3,
			24'h7FFFFF, 24'h800000, 16'h0001, 16'd1, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		// table full: lowest score goes
		plan.push_back(det_typed(24'h800000, 24'h7FFFFF, 16'h1234, ACT_REPLACE, 2'd2,
			24'h800000, 24'h7FFFFF, 16'h1234, 16'd1, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		plan.push_back(det_typed(24'h800000, 24'h7FFFFF, 16'hFFFF, ACT_MERGE, 2'd2,
			24'h800000, 24'h7FFFFF, 16'h8919, 16'd2, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		// averaging floors toward minus infinity
		plan.push_back(det_typed(24'h000001, 24'hFFFFFF, 16'h0001, ACT_MERGE, 2'd0,
			24'h000000, 24'hFFFFFF, 16'h2000, 16'd3, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		plan.push_back(det_typed(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, ACT_MERGE, 2'd1,
			24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'd2, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		// 1 m^2 threshold: distance exactly on it does not merge, just inside does
		plan.push_back(cfg_row(32'd65536));
		plan.push_back(det_typed(24'h000100, 24'hFFFFFF, 16'h0100, ACT_REPLACE, 2'd3,
			24'h000100, 24'hFFFFFF, 16'h0100, 16'd1, 1'b1, 2'd1, 24'h7FFFFF, 24'h7FFFFF));
		plan.push_back(det_row(24'h0000FF, 24'hFFFFFF, 16'h0100));
		// zero threshold: even an exact hit replaces; last two rows make a score tie
		plan.push_back(cfg_row(32'd0));
		plan.push_back(det_row(24'h7FFFFF, 24'h7FFFFF, 16'h0000));
		plan.push_back(det_row(24'h000000, 24'h000000, 16'h0000));
		plan.push_back(det_row(24'h000005, 24'h000005, 16'h1080));
		plan.push_back(det_row(24'h000009, 24'h000009, 16'h0200));
		plan.push_back(cfg_row(32'hFFFFFFFF));
		plan.push_back(det_row(24'h008000, 24'h008000, 16'hABCD));
		plan.push_back(det_row(24'h800000, 24'h800000, 16'h5555));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[h]) begin
			if (plan[h].kind == ROW_CFG) begin
				wait_drained();
				write_proximity(plan[h].radius);
			end else begin
				push_detection(plan[h].det, plan[h].fixed, plan[h].want);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: radius = DST_PROX_RESET;
				1: radius = 32'd65536;
				2: radius = 32'd0;
				3: radius = 32'hFFFFFFFF;
				4: radius = $urandom;
				default: radius = $urandom_range(0, 32'h0010_0000);
			endcase
			write_proximity(radius);
			idle_en = (ph != 2 && ph != 5);
			foreach (hub_x[h]) begin
				if (h % 2 == 0) begin
					hub_x[h] = 24'($urandom_range(0, 16'hFFFF)) - 24'h008000;
					hub_y[h] = 24'($urandom_range(0, 16'hFFFF)) - 24'h008000;
				end else begin
					hub_x[h] = 24'($urandom);
					hub_y[h] = 24'($urandom);
				end
			end
			// long output hold-off while words keep coming
			if (ph == 1)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
				push_detection(draw_detection(), 1'b0, '0);
			end
		end

		wait_drained();
		$display("Covered %0d detections (%0d merge, %0d fill, %0d replace), %0d words checked",
			dets_in, act_seen[ACT_MERGE], act_seen[ACT_FILL], act_seen[ACT_REPLACE], words_out);
		$display("%0d threshold writes incl. 0 and all-ones, long output hold-off, %0d cycles",
			cfg_writes, cycle_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- detection_spot_table.f -----
rtl/dst_pkg.sv
rtl/dst_sqacc.sv
rtl/detection_spot_table.sv
bench/testbench.sv
